FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, disabled while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/asrst_pkg.sv
// Shared constants, types and op codes for the alternating-sign range sum tree.
// No dependencies.
`default_nettype none

package asrst_pkg;

  localparam int SIZE    = 1024;
  localparam int LEVELS  = $clog2(SIZE);
  localparam int NODE_AW = LEVELS + 1;   // node index 1 .. 2*SIZE-1
  localparam int PTR_W   = NODE_AW + 1;  // also holds 2*SIZE
  localparam int NODE_W  = 32;
  localparam int DEPTH   = 2 * SIZE;

  localparam int IDX_W   = 10;
  localparam int VALUE_W = 16;
  localparam int RIGHT_W = 11;
  localparam int SUM_W   = 27;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef logic [NODE_AW-1:0] node_addr_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [NODE_W-1:0]  node_t;

  typedef struct packed {
    logic       en;
    node_addr_t addr;
    node_t      data;
  } ram_wr_t;

endpackage

`default_nettype wire

FILE: sv/asrst_ram.sv
// Node store: one write port, two registered read ports.
// Depends on asrst_pkg.
`default_nettype none

module asrst_ram
  import asrst_pkg::*;
(
  input  wire logic       clk,
  input  wire ram_wr_t    wr,
  input  wire node_addr_t rd_addr_a,
  input  wire node_addr_t rd_addr_b,
  output node_t           rd_data_a,
  output node_t           rd_data_b
);

  node_t node_mem [DEPTH];
  node_t rd_a_r;
  node_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      node_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= node_mem[rd_addr_a];
    rd_b_r <= node_mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

FILE: sv/alternating_sign_range_sum_tree_core.sv
// Assignment: per tree level a write with sibling read, then an add; the root is written last.
// Query: both range ends share one level step
// through the two read ports. One transaction at a time; no result for an assignment.
// Reset: synchronous, active low; then a clearing pass zeroes every node memory word, stall high.
// Only the even-first tree is stored: the odd-first tree is its negation node for node.
`default_nettype none

module alternating_sign_range_sum_tree_core
  import asrst_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_op,
  input  wire logic [IDX_W-1:0]          in_index,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic [IDX_W-1:0]          in_left,
  input  wire logic [RIGHT_W-1:0]        in_right,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [SUM_W-1:0]        out_sum
);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_UPD_WR  = 7'b0000100,
    ST_UPD_ADD = 7'b0001000,
    ST_QRY     = 7'b0010000,
    ST_QFIN    = 7'b0100000,
    ST_SPARE   = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  node_addr_t clr_r, clr_nxt;
  node_addr_t p_r, p_nxt;
  node_t      cur_r, cur_nxt;
  ptr_t       l_r, l_nxt;
  ptr_t       r_r, r_nxt;
  logic       odd_r, odd_nxt;
  node_t      acc_r, acc_nxt;
  logic       pa_r, pa_nxt;
  logic       pb_r, pb_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;

  ram_wr_t    wr;
  node_addr_t rd_addr_a, rd_addr_b;
  node_t      rd_data_a, rd_data_b;

  node_t            value_ext;
  logic [RIGHT_W-1:0] right_clamp;
  ptr_t             r_m1;
  node_t            q_total;

  asrst_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign value_ext   = {{(NODE_W-VALUE_W){in_value[VALUE_W-1]}}, in_value};
  assign right_clamp = (in_right > RIGHT_W'(SIZE)) ? RIGHT_W'(SIZE) : in_right;
  assign r_m1        = r_r - ptr_t'(1);
  assign q_total     = odd_r ? (node_t'(0) - acc_r) : acc_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    p_nxt         = p_r;
    cur_nxt       = cur_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    odd_nxt       = odd_r;
    acc_nxt       = acc_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_sum_nxt   = out_sum_r;
    wr            = '0;
    rd_addr_a     = '0;
    rd_addr_b     = '0;

    unique case (state_r)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_r;
        wr.data = '0;
        clr_nxt = clr_r + node_addr_t'(1);
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_ASSIGN) begin
            p_nxt     = node_addr_t'(SIZE) + node_addr_t'(in_index);
            // even-first tree keeps odd positions negated
            cur_nxt   = in_index[0] ? (node_t'(0) - value_ext) : value_ext;
            state_nxt = ST_UPD_WR;
          end else begin
            l_nxt     = ptr_t'(SIZE) + ptr_t'(in_left);
            r_nxt     = ptr_t'(SIZE) + ptr_t'(right_clamp);
            odd_nxt   = in_left[0];
            acc_nxt   = '0;
            pa_nxt    = 1'b0;
            pb_nxt    = 1'b0;
            state_nxt = ST_QRY;
          end
        end
      end
      ST_UPD_WR: begin
        wr.en     = 1'b1;
        wr.addr   = p_r;
        wr.data   = cur_r;
        rd_addr_a = p_r ^ node_addr_t'(1);
        if (p_r == node_addr_t'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_UPD_ADD;
        end
      end
      ST_UPD_ADD: begin
        cur_nxt   = cur_r + rd_data_a;
        p_nxt     = p_r >> 1;
        state_nxt = ST_UPD_WR;
      end
      ST_QRY: begin
        // fold in the nodes read on the previous level
        acc_nxt = acc_r + (pa_r ? rd_data_a : node_t'(0)) + (pb_r ? rd_data_b : node_t'(0));
        if (l_r < r_r) begin
          pa_nxt    = l_r[0];
          pb_nxt    = r_r[0];
          rd_addr_a = l_r[NODE_AW-1:0];
          rd_addr_b = r_m1[NODE_AW-1:0];
          l_nxt     = (l_r + ptr_t'(l_r[0])) >> 1;
          r_nxt     = (r_r - ptr_t'(r_r[0])) >> 1;
        end else begin
          pa_nxt    = 1'b0;
          pb_nxt    = 1'b0;
          state_nxt = ST_QFIN;
        end
      end
      ST_QFIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = q_total[SUM_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pa_r        <= 1'b0;
      pb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pa_r        <= pa_nxt;
      pb_r        <= pb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    cur_r     <= cur_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    odd_r     <= odd_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;

endmodule

`default_nettype wire

FILE: sv/asrst_checker.sv
// Port-level checks for the range sum tree core, bound into the core module.
// Depends on assert_macros.svh, asrst_pkg and alternating_sign_range_sum_tree_core.
`default_nettype none
`include "assert_macros.svh"

module asrst_checker
  import asrst_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    in_op,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [SUM_W-1:0] out_sum
);

  // result held until taken
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_sum), "stalled result changed")
  // one transaction in flight: busy straight after acceptance
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted back to back")
  // an assignment never raises a result
  `ASSERT_NEXT(a_assign_silent, clk, rst_n, in_valid && !in_stall && in_op == OP_ASSIGN && !out_valid, !out_valid, "assignment gave a result")

endmodule

bind alternating_sign_range_sum_tree_core asrst_checker u_asrst_checker (.*);

`default_nettype wire

FILE: dv/tb.sv
// Testbench for alternating_sign_range_sum_tree_core: directed, random and back-to-back tests.
// Keeps its own pair of alternating-sign sum trees to predict each range sum.
// Depends on asrst_pkg and the core RTL only.

module tb
  import asrst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 12000;
  localparam int DRAIN_CYCLES = 30;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_op = OP_ASSIGN;
  logic [IDX_W-1:0]          in_index = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [IDX_W-1:0]          in_left = '0;
  logic [RIGHT_W-1:0]        in_right = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SUM_W-1:0]   out_sum;

  // alt_tree[0]: element counted positive at even index; alt_tree[1]: at odd index
  logic [NODE_W-1:0]       alt_tree [2][2*SIZE];
  logic signed [SUM_W-1:0] range_sums_due [$];
  int                      fail_count = 0;
  int                      idle_cycles = 0;
  int                      stall_left = 0;
  bit                      steady_flow = 1'b0;

  alternating_sign_range_sum_tree_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_index (in_index),
    .in_value (in_value),
    .in_left  (in_left),
    .in_right (in_right),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sum  (out_sum)
  );

  always #6 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic void tree_store(input int t, input int unsigned pos,
                                     input logic [NODE_W-1:0] leaf);
    int unsigned p;
    p = pos + SIZE;
    alt_tree[t][p] = leaf;
    while (p > 1) begin
      p = p >> 1;
      alt_tree[t][p] = alt_tree[t][2*p] + alt_tree[t][2*p+1];
    end
  endfunction

  function automatic logic [NODE_W-1:0] tree_range_total(input int t, input int unsigned lo,
                                                         input int unsigned hi);
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    int unsigned l;
    int unsigned r;
    a = '0;
    b = '0;
    l = lo + SIZE;
    r = hi + SIZE;
    while (l < r) begin
      if (l[0]) begin
        a = a + alt_tree[t][l];
        l++;
      end
      if (r[0]) begin
        r--;
        b = b + alt_tree[t][r];
      end
      l = l >> 1;
      r = r >> 1;
    end
    return a + b;
  endfunction

  function automatic void predict_item(input logic op, input logic [IDX_W-1:0] idx,
                                       input logic signed [VALUE_W-1:0] val,
                                       input logic [IDX_W-1:0] lo,
                                       input logic [RIGHT_W-1:0] hi);
    logic [NODE_W-1:0] v;
    logic [NODE_W-1:0] total;
    int unsigned hi_c;
    if (op == OP_ASSIGN) begin
      if (idx < SIZE) begin
        v = {{(NODE_W-VALUE_W){val[VALUE_W-1]}}, val};
        tree_store(int'(idx[0]), int'(idx), v);
        tree_store(int'(!idx[0]), int'(idx), -v);
      end
    end else begin
      hi_c = (hi > SIZE) ? SIZE : int'(hi);
      total = '0;
      if (lo < hi_c)
        total = tree_range_total(int'(lo[0]), int'(lo), hi_c);
      range_sums_due.push_back(total[SUM_W-1:0]);
    end
  endfunction

  // ---------------- sender ----------------
  function automatic int pick_gap();
    int r;
    if (steady_flow)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Called just after a rising edge; returns just after one.
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val,
                           input logic [IDX_W-1:0] lo, input logic [RIGHT_W-1:0] hi);
    int gap;
    in_valid <= 1'b1;
    in_op    <= op;
    in_index <= idx;
    in_value <= val;
    in_left  <= lo;
    in_right <= hi;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_item(op, idx, val, lo, hi);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (range_sums_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return -16'sd1;
      default: return VALUE_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0, 1: return IDX_W'($urandom_range(0, 15));
      2: return IDX_W'($urandom_range(SIZE-16, SIZE-1));
      default: return IDX_W'($urandom_range(0, SIZE-1));
    endcase
  endfunction

  task automatic send_random_item();
    logic [IDX_W-1:0]   lo;
    logic [RIGHT_W-1:0] hi;
    lo = pick_index();
    case ($urandom_range(0, 9))
      0: hi = RIGHT_W'($urandom_range(0, 2*SIZE-1));
      1: hi = RIGHT_W'($urandom_range(0, lo));
      2: hi = RIGHT_W'($urandom_range(SIZE, 2*SIZE-1));
      3: hi = RIGHT_W'(lo) + RIGHT_W'(1);
      default: hi = RIGHT_W'($urandom_range(lo, SIZE));
    endcase
    if ($urandom_range(0, 99) < 45)
      send_item(OP_QUERY, IDX_W'($urandom_range(0, SIZE-1)), pick_value(), lo, hi);
    else
      send_item(OP_ASSIGN, pick_index(), pick_value(), lo, hi);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd0, 11'd1024);      // untouched array
    send_item(OP_ASSIGN, 10'd0, 16'sh7FFF, 10'd1023, 11'd2047);
    send_item(OP_ASSIGN, 10'd1023, 16'sh8000, 10'd0, 11'd0);
    send_item(OP_ASSIGN, 10'd1, 16'sh8000, 10'd0, 11'd0);
    send_item(OP_ASSIGN, 10'd1022, 16'sh7FFF, 10'd0, 11'd0);
    send_item(OP_ASSIGN, 10'd512, -16'sd1, 10'd0, 11'd0);
    send_item(OP_QUERY, 10'd1023, -16'sd1, 10'd0, 11'd1024);
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd1, 11'd1024);       // odd start
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd0, 11'd2047);       // end clamped
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd1023, 11'd1025);
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd1023, 11'd1024);
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd0, 11'd1);
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd5, 11'd5);          // empty
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd1023, 11'd0);       // reversed
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd600, 11'd1024);
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd1022, 11'd1024);
    send_item(OP_ASSIGN, 10'd0, 16'sd0, 10'd0, 11'd0);         // overwrite
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd0, 11'd2);
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd512, 11'd513);
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd0, 11'd0);
    send_item(OP_ASSIGN, 10'd682, 16'sh5555, 10'd0, 11'd0);
    send_item(OP_QUERY, 10'd0, 16'sd0, 10'd0, 11'd1024);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 1180; i++) begin
      send_random_item();
      if (i % 300 == 299)
        wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    wait_drained();
    steady_flow = 1'b1;
    for (int i = 0; i < 150; i++)
      send_random_item();
    steady_flow = 1'b0;
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (steady_flow) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:24]: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
        [25:27]: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(5, 30);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    logic signed [SUM_W-1:0] want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (range_sums_due.size() == 0) begin
        $error("unexpected result transaction, sum %0d", out_sum);
        fail_count++;
      end else begin
        want = range_sums_due.pop_front();
        if (out_sum !== want) begin
          $error("sum mismatch: expected %0d, actual %0d", want, out_sum);
          fail_count++;
        end
      end
    end
  end

  // watchdog: long spell with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    foreach (alt_tree[t, n])
      alt_tree[t][n] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix();
    test_back_to_back();
    in_valid <= 1'b0;
    @(posedge clk);
    while (range_sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (range_sums_due.size() != 0) begin
      $error("%0d range sums never arrived", range_sums_due.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/asrst_pkg.sv
sv/asrst_ram.sv
sv/alternating_sign_range_sum_tree_core.sv
sv/asrst_checker.sv
dv/tb.sv
